[src/rsst_pkg.sv]
// ----------------------------------------------------------------------------
// rsst_pkg: shared types and constants for the range sum segment tree unit
// Field widths, item and status codes, and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package rsst_pkg;

    localparam int IDX_W = 10;   // element / range index field
    localparam int VAL_W = 32;   // element value field
    localparam int SUM_W = 42;   // node sums and result sum
    localparam int CNT_W = 11;   // element_count register

    localparam int DEF_MAX_ELEMENTS = 1024;
    localparam int DEF_VALUE_BITS   = 32;

    localparam logic [CNT_W-1:0] CNT_RESET = 11'd1024;

    // item command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // result status codes
    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_BAD_RANGE = 1'b1;

    // controller -> datapath commands
    typedef struct packed {
        logic clr;      // write zero at sweep address, advance sweep
        logic load;     // capture the accepted item
        logic w_leaf;   // write leaf, fetch its sibling
        logic w_up;     // write parent sum, fetch next sibling
        logic q_init;   // fetch node at l
        logic q_l;      // fold left node, fetch node at r-1
        logic q_r;      // fold right node, shift bounds, fetch new l
        logic emit;     // register the result
    } t_dp_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic clr_last; // sweep at last node
        logic wr_ok;    // captured write index inside the array
        logic up_root;  // parent being written is the root
        logic invalid;  // captured range has start past clamped end
        logic more;     // bounds after this level still open
    } t_dp_stat;

endpackage

[src/rsst_ctrl.sv]
// ----------------------------------------------------------------------------
// rsst_ctrl: sequencer for the range sum segment tree unit
// Runs the clearing sweep, the leaf-to-root update and the range walk.
// ----------------------------------------------------------------------------
module rsst_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               i_cmd,
    output logic               busy,
    input  rsst_pkg::t_dp_stat i_stat,
    output rsst_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_W_LEAF,
        S_W_UP,
        S_Q_INIT,
        S_Q_L,
        S_Q_R
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state = (i_cmd == rsst_pkg::CMD_QUERY) ? S_Q_INIT : S_W_LEAF;
                end
            end
            S_W_LEAF: begin
                if (i_stat.wr_ok) begin
                    o_cmd.w_leaf = 1'b1;
                    n_state = S_W_UP;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_W_UP: begin
                o_cmd.w_up = 1'b1;
                if (i_stat.up_root) begin
                    n_state = S_IDLE;
                end
            end
            S_Q_INIT: begin
                if (i_stat.invalid) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.q_init = 1'b1;
                    n_state = S_Q_L;
                end
            end
            S_Q_L: begin
                o_cmd.q_l = 1'b1;
                n_state = S_Q_R;
            end
            S_Q_R: begin
                o_cmd.q_r = 1'b1;
                if (i_stat.more) begin
                    n_state = S_Q_L;
                end else begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

[src/rsst_dp.sv]
// ----------------------------------------------------------------------------
// rsst_dp: datapath for the range sum segment tree unit
// Node-sum memory, item capture, range clamp, sum adder and result register.
// ----------------------------------------------------------------------------
module rsst_dp #(
    parameter int MAX_ELEMENTS = rsst_pkg::DEF_MAX_ELEMENTS,
    parameter int VALUE_BITS   = rsst_pkg::DEF_VALUE_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rsst_pkg::t_dp_cmd                 i_cmd_dp,
    output rsst_pkg::t_dp_stat                o_stat,
    input  logic [rsst_pkg::IDX_W-1:0]        i_element_index,
    input  logic signed [rsst_pkg::VAL_W-1:0] i_element_value,
    input  logic [rsst_pkg::IDX_W-1:0]        i_range_start,
    input  logic [rsst_pkg::IDX_W-1:0]        i_range_end,
    input  logic                              i_cfg_wr_en,
    input  logic [rsst_pkg::CNT_W-1:0]        i_cfg_wr_data,
    output logic                              o_strobe,
    output logic signed [rsst_pkg::SUM_W-1:0] o_range_sum,
    output logic                              o_status
);

    localparam int SUM_W  = rsst_pkg::SUM_W;
    localparam int DEPTH  = 2 * MAX_ELEMENTS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int NODE_W = ADDR_W + 1;                 // holds 2*MAX for r
    localparam int CW     = (NODE_W > rsst_pkg::CNT_W) ? NODE_W + 1 : rsst_pkg::CNT_W + 1;
    localparam int VB     = (VALUE_BITS < 32) ? VALUE_BITS : 32;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    logic [SUM_W-1:0] r_mem [0:DEPTH-1];
    logic [SUM_W-1:0] r_rdata;
    logic [ADDR_W-1:0] raddr;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [SUM_W-1:0]  wdata;

    logic [rsst_pkg::CNT_W-1:0] r_count;
    logic [ADDR_W-1:0] r_clr_addr;

    logic [NODE_W-1:0] r_p;
    logic [SUM_W-1:0]  r_cur;
    logic              r_wr_ok;
    logic [NODE_W-1:0] r_l;
    logic [NODE_W-1:0] r_r;
    logic              r_invalid;
    logic [SUM_W-1:0]  r_acc;

    logic              r_out_vld;
    logic [SUM_W-1:0]  r_out_sum;
    logic              r_out_status;

    // item capture, range clamp
    logic [CW-1:0] cnt_x, used, last, end_x, end_c, start_x, idx_x, max_x;
    logic          ld_invalid;
    logic signed [VB-1:0]    v_low;
    logic signed [SUM_W-1:0] v_ext;

    // walk signals
    logic [NODE_W-1:0] p_up;
    logic [NODE_W-1:0] l_nx;
    logic [NODE_W-1:0] r_dec;
    logic [NODE_W-1:0] r_nx;
    logic [SUM_W-1:0]  sum_up;
    logic [SUM_W-1:0]  acc_nx;

    always_comb begin
        max_x   = CW'(MAX_ELEMENTS);
        cnt_x   = CW'(r_count);
        start_x = CW'(i_range_start);
        end_x   = CW'(i_range_end);
        idx_x   = CW'(i_element_index);
        if (cnt_x == '0) begin
            used = CW'(1);
        end else if (cnt_x > max_x) begin
            used = max_x;
        end else begin
            used = cnt_x;
        end
        last       = used - CW'(1);
        end_c      = (end_x > last) ? last : end_x;
        ld_invalid = (start_x > end_c);
        v_low      = i_element_value[VB-1:0];
        v_ext      = SUM_W'(v_low);
    end

    assign p_up   = r_p >> 1;
    assign sum_up = r_cur + r_rdata;
    assign r_dec  = r_r - NODE_W'(r_r[0]);
    assign l_nx   = r_l >> 1;
    assign r_nx   = r_dec >> 1;
    assign acc_nx = r_r[0] ? (r_acc + r_rdata) : r_acc;

    // memory port selection: one write, one read per cycle
    always_comb begin
        we    = 1'b0;
        waddr = r_clr_addr;
        wdata = '0;
        raddr = r_l[ADDR_W-1:0];
        if (i_cmd_dp.clr) begin
            we = 1'b1;
        end else if (i_cmd_dp.w_leaf) begin
            we    = 1'b1;
            waddr = r_p[ADDR_W-1:0];
            wdata = r_cur;
        end else if (i_cmd_dp.w_up) begin
            we    = 1'b1;
            waddr = p_up[ADDR_W-1:0];
            wdata = sum_up;
        end
        if (i_cmd_dp.w_leaf) begin
            raddr = r_p[ADDR_W-1:0] ^ ADDR_W'(1);      // sibling of leaf
        end else if (i_cmd_dp.w_up) begin
            raddr = p_up[ADDR_W-1:0] ^ ADDR_W'(1);     // sibling of parent
        end else if (i_cmd_dp.q_init) begin
            raddr = r_l[ADDR_W-1:0];                   // first left node
        end else if (i_cmd_dp.q_l) begin
            raddr = ADDR_W'(r_r - NODE_W'(1));
        end else if (i_cmd_dp.q_r) begin
            raddr = l_nx[ADDR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rdata <= r_mem[raddr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= rsst_pkg::CNT_RESET;
            r_clr_addr <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_count <= i_cfg_wr_data;
            end
            if (i_cmd_dp.clr) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            r_out_vld <= i_cmd_dp.emit;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd_dp.load) begin
            r_p       <= NODE_W'(idx_x + max_x);
            r_cur     <= v_ext;
            r_wr_ok   <= (idx_x < max_x);
            r_l       <= NODE_W'(start_x + max_x);
            r_r       <= NODE_W'(end_c + max_x + CW'(1));
            r_invalid <= ld_invalid;
            r_acc     <= '0;
        end
        if (i_cmd_dp.w_up) begin
            r_cur <= sum_up;
            r_p   <= p_up;
        end
        if (i_cmd_dp.q_l) begin
            if (r_l[0]) begin
                r_acc <= r_acc + r_rdata;
            end
            r_l <= r_l + NODE_W'(r_l[0]);
        end
        if (i_cmd_dp.q_r) begin
            r_acc <= acc_nx;
            r_l   <= l_nx;
            r_r   <= r_nx;
        end
        if (i_cmd_dp.emit) begin
            r_out_sum    <= r_invalid ? '0 : acc_nx;
            r_out_status <= r_invalid ? rsst_pkg::STATUS_BAD_RANGE : rsst_pkg::STATUS_OK;
        end
    end

    assign o_stat.clr_last = (r_clr_addr == LAST_ADDR);
    assign o_stat.wr_ok    = r_wr_ok;
    assign o_stat.up_root  = (p_up == NODE_W'(1));
    assign o_stat.invalid  = r_invalid;
    assign o_stat.more     = (l_nx < r_nx);

    assign o_strobe    = r_out_vld;
    assign o_range_sum = r_out_sum;
    assign o_status    = r_out_status;

endmodule

[src/range_sum_segment_tree_unit.sv]
// ----------------------------------------------------------------------------
// range_sum_segment_tree_unit: point-update, range-sum segment tree
// Sequencer plus datapath over one node-sum memory of 2*MAX_ELEMENTS words.
// ----------------------------------------------------------------------------
// Write item: one node write per tree level, with the sibling fetch overlapped
//   with the write; no result.
// Query item: a left and a right node step per tree level walked, or an immediate
//   result for an invalid range; strobe in the first idle cycle; the single read port.
// Items: a new item is accepted only while idle, after the last is done; results cannot stall.
// Reset: synchronous, active low, then a clearing pass over all 2*MAX_ELEMENTS words.
module range_sum_segment_tree_unit #(
    parameter int MAX_ELEMENTS = rsst_pkg::DEF_MAX_ELEMENTS,
    parameter int VALUE_BITS   = rsst_pkg::DEF_VALUE_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // item command port
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_cmd,
    input  logic [rsst_pkg::IDX_W-1:0]        i_element_index,
    input  logic signed [rsst_pkg::VAL_W-1:0] i_element_value,
    input  logic [rsst_pkg::IDX_W-1:0]        i_range_start,
    input  logic [rsst_pkg::IDX_W-1:0]        i_range_end,
    // element_count register
    input  logic                              i_cfg_wr_en,
    input  logic [rsst_pkg::CNT_W-1:0]        i_cfg_wr_data,
    // result
    output logic                              o_strobe,
    output logic signed [rsst_pkg::SUM_W-1:0] o_range_sum,
    output logic                              o_status
);

    rsst_pkg::t_dp_cmd  dp_cmd;
    rsst_pkg::t_dp_stat dp_stat;

    // Sequencer: decides the item type on accept, then steps the datapath
    // through the sweep, the leaf-to-root update or the range walk.
    rsst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_cmd   (i_cmd),
        .busy    (busy),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    // Datapath: the item is captured on accept, so inputs may change while
    // busy. Range end clamp and start check happen at capture.
    rsst_dp #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .VALUE_BITS   (VALUE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_dp        (dp_cmd),
        .o_stat          (dp_stat),
        .i_element_index (i_element_index),
        .i_element_value (i_element_value),
        .i_range_start   (i_range_start),
        .i_range_end     (i_range_end),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .o_strobe        (o_strobe),
        .o_range_sum     (o_range_sum),
        .o_status        (o_status)
    );

    // an accepted item always occupies the block for the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    // a result only follows a cycle of work
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result strobe without preceding work");

    // results never come in consecutive cycles
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe repeated");

    // a rejected range carries a zero sum
    a_bad_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status == rsst_pkg::STATUS_BAD_RANGE)) |-> (o_range_sum == '0))
        else $error("invalid range with nonzero sum");

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for range_sum_segment_tree_unit
// Writes elements and queries range sums through the start/busy command port.
// A shadow copy of the element array and the element_count register predicts
// every query result. A checker compares each strobed result with the oldest
// prediction. Sender gaps are random, and element_count is changed between
// phases while the unit is idle.
// ----------------------------------------------------------------------------
module tb;

    localparam int IDX_W = rsst_pkg::IDX_W;
    localparam int VAL_W = rsst_pkg::VAL_W;
    localparam int SUM_W = rsst_pkg::SUM_W;
    localparam int CNT_W = rsst_pkg::CNT_W;

    localparam int NUM_ELEMENTS   = rsst_pkg::DEF_MAX_ELEMENTS;
    // A write keeps busy high and gives no strobe. Wait
    // well past its end before touching the register.
    localparam int SETTLE_CYCLES  = 40;
    // Idle-cycle limit. It covers the clearing pass after reset,
    // the longest sender gap and a full query, with a wide margin.
    localparam int WATCHDOG_LIMIT = 12000;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic                    status;
    } t_range_result;

    // ------------------------------------------------------------------------
    // DUT connections; every input holds a known value from time zero
    // ------------------------------------------------------------------------
    logic                    i_clk           = 1'b0;
    logic                    i_rst_n         = 1'b0;
    logic                    start           = 1'b0;
    logic                    busy;
    logic                    i_cmd           = rsst_pkg::CMD_WRITE;
    logic [IDX_W-1:0]        i_element_index = '0;
    logic signed [VAL_W-1:0] i_element_value = '0;
    logic [IDX_W-1:0]        i_range_start   = '0;
    logic [IDX_W-1:0]        i_range_end     = '0;
    logic                    i_cfg_wr_en     = 1'b0;
    logic [CNT_W-1:0]        i_cfg_wr_data   = '0;
    logic                    o_strobe;
    logic signed [SUM_W-1:0] o_range_sum;
    logic                    o_status;

    // ------------------------------------------------------------------------
    // Shadow state and the queue of predicted query results
    // ------------------------------------------------------------------------
    logic signed [VAL_W-1:0] element_shadow [NUM_ELEMENTS];
    logic [CNT_W-1:0]        count_shadow;
    t_range_result           pending_sums [$];
    int                      err_count   = 0;
    int                      idle_cycles = 0;
    bit                      no_idle     = 1'b0;   // burst stretch: no sender gaps

    always #5 i_clk = ~i_clk;

    range_sum_segment_tree_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cmd           (i_cmd),
        .i_element_index (i_element_index),
        .i_element_value (i_element_value),
        .i_range_start   (i_range_start),
        .i_range_end     (i_range_end),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .o_strobe        (o_strobe),
        .o_range_sum     (o_range_sum),
        .o_status        (o_status)
    );

    // ------------------------------------------------------------------------
    // Range sum predictor.
    // Count 0 acts as 1 and counts above the array size act as the array size.
    // The range end clamps to the last element in use. A start past the
    // clamped end gives a bad-range status with a zero sum. At these widths
    // the sum of all elements always fits in the result, so no wrap occurs.
    // ------------------------------------------------------------------------
    function automatic t_range_result predict_range_sum(input logic [IDX_W-1:0] lo_idx,
                                                        input logic [IDX_W-1:0] hi_idx);
        t_range_result res;
        int            used;
        int            hi_clamped;
        longint        acc;
        used = int'(count_shadow);
        if (used == 0) used = 1;
        if (used > NUM_ELEMENTS) used = NUM_ELEMENTS;
        hi_clamped = (int'(hi_idx) > used - 1) ? used - 1 : int'(hi_idx);
        acc = 0;
        if (int'(lo_idx) > hi_clamped) begin
            res.status = rsst_pkg::STATUS_BAD_RANGE;
        end else begin
            res.status = rsst_pkg::STATUS_OK;
            for (int i = int'(lo_idx); i <= hi_clamped; i++) begin
                acc += longint'(element_shadow[i]);
            end
        end
        res.sum = acc[SUM_W-1:0];
        return res;
    endfunction

    // Mostly short gaps, sometimes none, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle) return 0;
        if (r < 45) return 0;
        if (r < 80) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 24);
        return $urandom_range(30, 150);
    endfunction

    // ------------------------------------------------------------------------
    // Send one item. start stays high afterwards so that a back-to-back item
    // needs only one assignment; lower_start must run before any wait.
    // ------------------------------------------------------------------------
    task automatic issue_item(input logic cmd, input logic [IDX_W-1:0] idx,
                              input logic signed [VAL_W-1:0] val,
                              input logic [IDX_W-1:0] lo_idx, input logic [IDX_W-1:0] hi_idx);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_cmd           <= cmd;
        i_element_index <= idx;
        i_element_value <= val;
        i_range_start   <= lo_idx;
        i_range_end     <= hi_idx;
        // values read just after the edge are the ones the edge sampled
        do @(posedge i_clk); while (busy !== 1'b0);
        if (cmd == rsst_pkg::CMD_WRITE) begin
            element_shadow[idx] = val;
        end else begin
            pending_sums.push_back(predict_range_sum(lo_idx, hi_idx));
        end
    endtask

    task automatic write_item(input logic [IDX_W-1:0] idx, input logic signed [VAL_W-1:0] val);
        issue_item(rsst_pkg::CMD_WRITE, idx, val, IDX_W'($urandom), IDX_W'($urandom));
    endtask

    task automatic query_item(input logic [IDX_W-1:0] lo_idx, input logic [IDX_W-1:0] hi_idx);
        issue_item(rsst_pkg::CMD_QUERY, IDX_W'($urandom), VAL_W'($urandom), lo_idx, hi_idx);
    endtask

    task automatic lower_start();
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    // Hold off until every predicted result has been strobed out
    task automatic wait_results_drained();
        lower_start();
        while (pending_sums.size() != 0) @(posedge i_clk);
    endtask

    // Register writes only while idle: drained, then past any trailing write
    task automatic set_element_count(input logic [CNT_W-1:0] count_val);
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= count_val;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= CNT_W'($urandom);
        count_shadow = count_val;
    endtask

    // ------------------------------------------------------------------------
    // Result checker: one strobe per query, compared with the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_range_result exp_res;
        if (i_rst_n && o_strobe === 1'b1) begin
            if (pending_sums.size() == 0) begin
                $error("unexpected result: range_sum %0d status %0b", o_range_sum, o_status);
                err_count++;
            end else begin
                exp_res = pending_sums.pop_front();
                if (o_range_sum !== exp_res.sum) begin
                    $error("range_sum expected %0d actual %0d", exp_res.sum, o_range_sum);
                    err_count++;
                end
                if (o_status !== exp_res.status) begin
                    $error("status expected %0b actual %0b", exp_res.status, o_status);
                    err_count++;
                end
            end
        end
    end

    // Watchdog: ends the run after too many cycles with neither an accepted
    // item nor a result
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && busy === 1'b0) || o_strobe === 1'b1) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[range_sum_segment_tree_unit] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------

    // Extreme values at both ends of the array, full and single-element ranges
    task automatic test_value_extremes();
        write_item(10'd0, 32'sh8000_0000);
        write_item(10'd1023, 32'sh7FFF_FFFF);
        write_item(10'd1, -32'sd1);
        write_item(10'd1022, 32'sd1);
        write_item(10'd512, 32'sh5555_5555);
        write_item(10'd511, 32'shAAAA_AAAA);
        query_item(10'd0, 10'd1023);
        query_item(10'd0, 10'd0);
        query_item(10'd1023, 10'd1023);
        query_item(10'd0, 10'd1);
        query_item(10'd511, 10'd512);
        query_item(10'd1, 10'd1022);
        lower_start();
    endtask

    // Start past end gives a bad-range status and a zero sum
    task automatic test_invalid_ranges();
        query_item(10'd5, 10'd4);
        query_item(10'd1023, 10'd0);
        lower_start();
    endtask

    // Count 0 acts as one element; counts past the array act as full size
    task automatic test_count_clamping();
        set_element_count(11'd0);
        query_item(10'd0, 10'd1023);
        query_item(10'd1, 10'd1023);
        set_element_count(11'd2047);
        query_item(10'd0, 10'd1023);
        query_item(10'd1023, 10'd1023);
        lower_start();
    endtask

    // A write past the count is stored but stays hidden until the count grows
    task automatic test_hidden_writes();
        set_element_count(11'd10);
        write_item(10'd500, 32'sd77);
        query_item(10'd0, 10'd1023);
        query_item(10'd500, 10'd500);
        set_element_count(11'd1024);
        query_item(10'd500, 10'd500);
        lower_start();
    endtask

    // Random traffic under one count setting. A burst stretch runs without
    // gaps; halfway through, the sender pauses until all results are in.
    task automatic test_random_traffic(input logic [CNT_W-1:0] count_val, input int n_items);
        int used;
        int span;
        int r;
        logic [IDX_W-1:0] lo_idx;
        logic [IDX_W-1:0] hi_idx;
        logic signed [VAL_W-1:0] val;
        set_element_count(count_val);
        used = int'(count_val);
        if (used == 0) used = 1;
        if (used > NUM_ELEMENTS) used = NUM_ELEMENTS;
        span = (used + 3 > NUM_ELEMENTS - 1) ? NUM_ELEMENTS - 1 : used + 3;
        for (int k = 0; k < n_items; k++) begin
            no_idle = (k >= n_items / 4 && k < n_items / 2);
            if (k == n_items / 2) wait_results_drained();
            r = $urandom_range(0, 99);
            if (r < 45) begin
                // writes mostly land inside the range in use
                case ($urandom_range(0, 9))
                    0:       val = 32'sh8000_0000;
                    1:       val = 32'sh7FFF_FFFF;
                    default: val = VAL_W'($urandom);
                endcase
                if ($urandom_range(0, 9) < 7) begin
                    write_item(IDX_W'($urandom_range(0, used - 1)), val);
                end else begin
                    write_item(IDX_W'($urandom), val);
                end
            end else begin
                if ($urandom_range(0, 1) == 0) begin
                    lo_idx = IDX_W'($urandom_range(0, span));
                    hi_idx = IDX_W'($urandom_range(0, span));
                    if (lo_idx > hi_idx && $urandom_range(0, 3) != 0) begin
                        {lo_idx, hi_idx} = {hi_idx, lo_idx};
                    end
                end else begin
                    lo_idx = IDX_W'($urandom);
                    hi_idx = IDX_W'($urandom);
                end
                query_item(lo_idx, hi_idx);
            end
        end
        no_idle = 1'b0;
        lower_start();
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [CNT_W-1:0] phase_counts [10];
        for (int i = 0; i < NUM_ELEMENTS; i++) element_shadow[i] = '0;
        count_shadow = rsst_pkg::CNT_RESET;
        phase_counts = '{11'd1024, 11'd1, 11'd0, 11'd2047, 11'd1025,
                         11'd37, 11'd512, 11'd2, 11'd1024, 11'd1024};
        phase_counts[7] = CNT_W'($urandom_range(2, 1023));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_value_extremes();
        test_invalid_ranges();
        test_count_clamping();
        test_hidden_writes();
        foreach (phase_counts[p]) test_random_traffic(phase_counts[p], 160);

        // drain, then let any trailing write finish
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("[range_sum_segment_tree_unit] OK");
        end else begin
            $display("[range_sum_segment_tree_unit] ERROR");
        end
        $finish;
    end

endmodule
